[hw/rtl/pip_pkg.sv]
// shared constants and types for the point-in-polygon winding block
package pip_pkg;
   localparam int MAX_VERTICES = 32;
   localparam int COORD_BITS   = 16;
   localparam int BOARD_BITS   = 15;
   localparam int IDX_BITS     = $clog2(MAX_VERTICES);
   localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
   localparam int OPND_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * OPND_BITS;
   localparam int SUM_BITS     = PROD_BITS + 1;
   localparam int WIND_BITS    = $clog2(2 * MAX_VERTICES + 1) + 1;
   localparam int OUT_BITS     = 8;
   localparam int CSR_BITS     = 1;
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

   localparam logic [CSR_BITS-1:0] REG_BOARD_WIDTH  = 1'd0;
   localparam logic [CSR_BITS-1:0] REG_BOARD_HEIGHT = 1'd1;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEST   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } vertex_type;
endpackage

[hw/rtl/pip_vram.sv]
// vertex memory, one write port and one registered read port
module pip_vram import pip_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  vertex_type          wr_data,
   input  logic [IDX_BITS-1:0] rd_addr,
   output vertex_type          rd_data
);
   vertex_type mem [MAX_VERTICES];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/pip_mul.sv]
// shared signed multiplier with registered product
module pip_mul import pip_pkg::*; (
   input  logic                        clock,
   input  logic signed [OPND_BITS-1:0] op_a,
   input  logic signed [OPND_BITS-1:0] op_b,
   output logic signed [PROD_BITS-1:0] prod
);
   logic signed [PROD_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;
endmodule

[hw/rtl/point_in_polygon_winding.sv]
// top level: polygon store, edge sequencer and crossing evaluation
//
//  channel  dir  handshake                 payload
//  req      in   req_tvalid / req_tready   tuser cmd, tdata coord_x, coord_y
//  rsp      out  rsp_tvalid / rsp_tready   tdata inside_res, winding
//  csr      in   csr_we                    csr_addr, csr_wdata
//
//  clear and append complete in the idle state; a test walks every edge in turn,
//  computing eight products per edge through the one shared multiplier plus fetch and
//  evaluation; a test on an empty polygon goes straight to the result.
//  reset empties the polygon and sets both board registers to 32767.
//  req_tready is low while a test runs and while a finished result waits for a
//  full output register.
module point_in_polygon_winding import pip_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_tuser,  // cmd
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // coord_x, coord_y
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,  // inside_res, winding, zero fill
   input  logic                     csr_we,
   input  logic [CSR_BITS-1:0]      csr_addr,
   input  logic [BOARD_BITS-1:0]    csr_wdata
);
   typedef enum logic [2:0] {
      S_IDLE, S_LOAD0, S_FIRST, S_FETCH, S_GETB, S_MUL, S_EVAL, S_DONE
   } state_type;

   state_type                    state_ff;
   logic [CNT_BITS-1:0]          count_ff;
   logic [IDX_BITS-1:0]          idx_ff;
   logic [3:0]                   step_ff;
   logic signed [WIND_BITS-1:0]  wind_ff, wind_in;
   logic [BOARD_BITS-1:0]        width_ff, height_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   vertex_type                   va_ff, vb_ff, first_ff;
   logic signed [PROD_BITS-1:0]  prod_ff [8];
   logic                         rsp_valid_ff;
   logic                         rsp_inside_ff;
   logic [OUT_BITS-1:0]          rsp_wind_ff;

   logic                         req_fire;
   cmd_type                      cmd;
   vertex_type                   req_vtx, rd_vtx;
   logic                         wr_en;
   logic [IDX_BITS-1:0]          rd_addr;
   logic [CNT_BITS-1:0]          next_idx;
   logic                         last_edge;
   logic signed [OPND_BITS-1:0]  op_a, op_b, mul_a, mul_b;
   logic signed [PROD_BITS-1:0]  mul_p;
   logic signed [OPND_BITS-1:0]  dx, dy, sx, sy, ax, ay, hh, ww;
   logic signed [SUM_BITS-1:0]   v_d, v_tn, v_un, h_d, h_tn, h_un, s_sum;
   logic                         v_hit, h_hit;
   logic signed [WIND_BITS-1:0]  contrib;
   logic [OUT_BITS-1:0]          wind_sat;

   function automatic logic strict_in(input logic signed [SUM_BITS-1:0] tn,
                                      input logic signed [SUM_BITS-1:0] un,
                                      input logic signed [SUM_BITS-1:0] d);
      logic pos, neg;
      pos = (d > 0) && (tn > 0) && (tn < d) && (un > 0) && (un < d);
      neg = (d < 0) && (tn < 0) && (tn > d) && (un < 0) && (un > d);
      return pos || neg;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign req_vtx.x  = req_tdata[COORD_BITS-1:0];
   assign req_vtx.y  = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign wr_en      = req_fire && (cmd == CMD_APPEND) &&
                       (count_ff < CNT_BITS'(MAX_VERTICES));

   assign next_idx  = CNT_BITS'(idx_ff) + CNT_BITS'(1);
   assign last_edge = (next_idx >= count_ff);
   assign rd_addr   = (state_ff == S_FETCH) ? next_idx[IDX_BITS-1:0] : '0;

   pip_vram u_vram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (req_vtx),
      .rd_addr (rd_addr),
      .rd_data (rd_vtx)
   );

   assign dx = OPND_BITS'(va_ff.x) - OPND_BITS'(px_ff);
   assign dy = OPND_BITS'(va_ff.y) - OPND_BITS'(py_ff);
   assign sx = OPND_BITS'(vb_ff.x) - OPND_BITS'(va_ff.x);
   assign sy = OPND_BITS'(vb_ff.y) - OPND_BITS'(va_ff.y);
   assign ax = OPND_BITS'(va_ff.x);
   assign ay = OPND_BITS'(va_ff.y);
   assign hh = signed'({{(OPND_BITS-BOARD_BITS){1'b0}}, height_ff});
   assign ww = signed'({{(OPND_BITS-BOARD_BITS){1'b0}}, width_ff});

   always_comb begin
      case (step_ff)
         4'd0:    begin op_a = dx; op_b = sy; end
         4'd1:    begin op_a = ay; op_b = sx; end
         4'd2:    begin op_a = hh; op_b = sx; end
         4'd3:    begin op_a = dx; op_b = hh; end
         4'd4:    begin op_a = dy; op_b = sx; end
         4'd5:    begin op_a = ax; op_b = sy; end
         4'd6:    begin op_a = ww; op_b = sy; end
         4'd7:    begin op_a = dy; op_b = ww; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign mul_a = op_a;
   assign mul_b = op_b;

   pip_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   always_comb begin
      v_d   = -SUM_BITS'(prod_ff[2]);
      v_tn  = SUM_BITS'(prod_ff[0]) - SUM_BITS'(prod_ff[1]);
      v_un  = SUM_BITS'(prod_ff[3]);
      h_d   = SUM_BITS'(prod_ff[6]);
      h_tn  = SUM_BITS'(prod_ff[5]) - SUM_BITS'(prod_ff[4]);
      h_un  = -SUM_BITS'(prod_ff[7]);
      s_sum = SUM_BITS'(prod_ff[0]) - SUM_BITS'(prod_ff[4]);
      v_hit = strict_in(v_tn, v_un, v_d);
      h_hit = strict_in(h_tn, h_un, h_d);
      contrib = (s_sum > 0) ? WIND_BITS'(1) : -WIND_BITS'(1);
      wind_in = wind_ff;
      if (v_hit) begin
         wind_in = wind_in + contrib;
      end
      if (h_hit) begin
         wind_in = wind_in + contrib;
      end
   end

   always_comb begin
      if (32'(wind_ff) > 32'sd127) begin
         wind_sat = 8'd127;
      end else if (32'(wind_ff) < -32'sd128) begin
         wind_sat = 8'h80;
      end else begin
         wind_sat = OUT_BITS'(32'(wind_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         wind_ff      <= '0;
         width_ff     <= '1;
         height_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_BOARD_WIDTH:  width_ff  <= csr_wdata;
               REG_BOARD_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (cmd)
                     CMD_CLEAR:  count_ff <= '0;
                     CMD_APPEND: begin
                        if (wr_en) begin
                           count_ff <= count_ff + CNT_BITS'(1);
                        end
                     end
                     CMD_TEST: begin
                        px_ff   <= req_vtx.x;
                        py_ff   <= req_vtx.y;
                        idx_ff  <= '0;
                        wind_ff <= '0;
                        state_ff <= (count_ff == '0) ? S_DONE : S_LOAD0;
                     end
                     default: ;
                  endcase
               end
            end
            S_LOAD0: state_ff <= S_FIRST;
            S_FIRST: begin
               va_ff    <= rd_vtx;
               first_ff <= rd_vtx;
               state_ff <= S_FETCH;
            end
            S_FETCH: state_ff <= S_GETB;
            S_GETB: begin
               vb_ff    <= last_edge ? first_ff : rd_vtx;
               step_ff  <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (step_ff != 4'd0) begin
                  prod_ff[step_ff[2:0] - 3'd1] <= mul_p;
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd8) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               wind_ff <= wind_in;
               if (last_edge) begin
                  state_ff <= S_DONE;
               end else begin
                  va_ff    <= vb_ff;
                  idx_ff   <= idx_ff + IDX_BITS'(1);
                  state_ff <= S_FETCH;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= (wind_ff != '0);
                  rsp_wind_ff   <= wind_sat;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_wind_ff, rsp_inside_ff};

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_VERTICES))
      else $error("vertex count beyond capacity");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(count_ff))
      else $error("vertex count changed during a test");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (CNT_BITS'(idx_ff) < count_ff))
      else $error("edge index past vertex count");
   a_wind_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(wind_ff) <= 2 * MAX_VERTICES) && (32'(wind_ff) >= -2 * MAX_VERTICES))
      else $error("winding count out of range");
endmodule
